FILE: rtl/vgis_pkg.sv
// Shared widths, opcodes and constants of the vector generator instruction step.
package vgis_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 4;

    localparam int WORD_W  = 16;
    localparam int OP_W    = 4;
    localparam int BEAM_W  = 32;
    localparam int MAG_W   = 10;
    localparam int VEC_W   = MAG_W + 1;
    localparam int TEMP_W  = 4;
    localparam int Z_W     = 4;
    localparam int INT_W   = 7;
    localparam int POS_W   = 14;
    localparam int DISP_W  = 19;

    // Scale value at which the vector delta is neither shifted left nor right.
    localparam int SHIFT_PIVOT = 9;

    // Display mapping: beam fixed point to display units.
    localparam int DISP_SHIFT  = 11;
    localparam int DISP_OFFSET = 17000;

    // Center about which positions are mirrored, on a normal and on a flipped screen.
    localparam int POS_CENTER = 1024;

    // A vector draws a visible line only when its z is above this value.
    localparam int Z_DRAW_MIN = 1;

    localparam logic [WORD_W-1:0] PC_RESET = 16'h8000;
    localparam logic [WORD_W-1:0] PC_STEP  = 16'd2;

    localparam logic [OP_W-1:0] OP_LONG_LAST = 4'h9;
    localparam logic [OP_W-1:0] OP_POS       = 4'hA;
    localparam logic [OP_W-1:0] OP_HALT      = 4'hB;
    localparam logic [OP_W-1:0] OP_CALL      = 4'hC;
    localparam logic [OP_W-1:0] OP_RET       = 4'hD;
    localparam logic [OP_W-1:0] OP_JUMP      = 4'hE;
    localparam logic [OP_W-1:0] OP_SHORT     = 4'hF;

endpackage

FILE: rtl/vector_generator_instruction_step.sv
// Top level of the vector generator instruction step.
//
// This block executes one vector-generator instruction per transfer on the
// s_ channel and returns one result transfer on the m_ channel. Each input
// gives the instruction word at the current program address together with
// the word after it; the result gives the next fetch address, the line that
// a visible vector draws (already mapped to display units), its intensity,
// the vector time and the halt and stack-error flags. The block keeps the
// program address, a return stack of STACK_DEPTH entries, the global scale
// and the fixed-point beam position with FRAC_BITS fraction bits. An item
// passes from the input register into the result register, and the
// sustained rate is one instruction per cycle while the sink is ready; the
// update of the architectural state at each executed instruction is what
// sets that rate. Both registers keep moving while the sink is ready, and a
// new transfer is taken while a result waits as long as the input register
// is free. screen_flip is written through cfg_wr_en and cfg_wr_data and
// should only change while no instruction is in flight.
module vector_generator_instruction_step
    import vgis_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [WORD_W-1:0]        s_first_word,
    input  logic [WORD_W-1:0]        s_second_word,
    input  logic                     s_restart,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [WORD_W-1:0]        m_next_address,
    output logic                     m_draw_valid,
    output logic signed [DISP_W-1:0] m_line_x0,
    output logic signed [DISP_W-1:0] m_line_y0,
    output logic signed [DISP_W-1:0] m_line_x1,
    output logic signed [DISP_W-1:0] m_line_y1,
    output logic [INT_W-1:0]         m_intensity,
    output logic [TEMP_W-1:0]        m_time_units,
    output logic                     m_halted,
    output logic                     m_stack_error
);

    // The stack pointer must hold the depth itself; the index only the entries.
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Configuration.
    logic screen_flip_reg;

    // Input register.
    logic              in_valid_reg;
    logic [WORD_W-1:0] first_reg;
    logic [WORD_W-1:0] second_reg;
    logic              restart_reg;

    // Architectural state.
    logic [WORD_W-1:0] pc_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [TEMP_W-1:0] scale_reg;
    logic [BEAM_W-1:0] beam_x_reg;
    logic [BEAM_W-1:0] beam_y_reg;
    logic              halt_reg;
    logic [WORD_W-1:0] stack_reg [STACK_DEPTH];

    // Result register.
    logic                     out_valid_reg;
    logic [WORD_W-1:0]        next_address_reg;
    logic                     draw_valid_reg;
    logic signed [DISP_W-1:0] line_x0_reg;
    logic signed [DISP_W-1:0] line_y0_reg;
    logic signed [DISP_W-1:0] line_x1_reg;
    logic signed [DISP_W-1:0] line_y1_reg;
    logic [INT_W-1:0]         intensity_reg;
    logic [TEMP_W-1:0]        time_units_reg;
    logic                     halted_reg;
    logic                     stack_error_reg;

    // Handshake.
    logic adv_out;
    logic exec;
    logic in_take;

    // State as seen by the instruction, after an optional restart.
    logic [WORD_W-1:0] eff_pc;
    logic [SP_W-1:0]   eff_sp;
    logic [TEMP_W-1:0] eff_scale;
    logic [BEAM_W-1:0] eff_bx;
    logic [BEAM_W-1:0] eff_by;
    logic              eff_halt;

    // Decode.
    logic [OP_W-1:0]   op;
    logic              is_long;
    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    logic              neg_x;
    logic              neg_y;
    logic [TEMP_W-1:0] temp_base;
    logic [TEMP_W-1:0] vec_temp;
    logic [Z_W-1:0]    vec_z;
    logic [BEAM_W-1:0] dx;
    logic [BEAM_W-1:0] dy;

    // Execute.
    logic [WORD_W-1:0]        pc_seq;
    logic [WORD_W-1:0]        jump_target;
    logic [SP_W-1:0]          sp_dec;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [BEAM_W-1:0]        nx;
    logic [BEAM_W-1:0]        ny;
    logic [WORD_W-1:0]        pc_next;
    logic [SP_W-1:0]          sp_next;
    logic [TEMP_W-1:0]        scale_next;
    logic [BEAM_W-1:0]        beam_x_next;
    logic [BEAM_W-1:0]        beam_y_next;
    logic                     halt_next;
    logic                     push_en;
    logic                     vec;
    logic                     draw;
    logic                     serr;
    logic signed [DISP_W-1:0] disp_x0;
    logic signed [DISP_W-1:0] disp_y0;
    logic signed [DISP_W-1:0] disp_x1;
    logic signed [DISP_W-1:0] disp_y1;

    // The result register advances when it is empty or being drained, and
    // the input register frees up whenever its item moves on.
    assign adv_out = !out_valid_reg || m_ready;
    assign exec    = in_valid_reg && adv_out;
    assign s_ready = !in_valid_reg || adv_out;
    assign in_take = s_valid && s_ready;

    // A restart resets all architectural state but the return stack entries before the word runs.
    always_comb begin
        eff_pc    = restart_reg ? PC_RESET : pc_reg;
        eff_sp    = restart_reg ? '0 : sp_reg;
        eff_scale = restart_reg ? '0 : scale_reg;
        eff_bx    = restart_reg ? '0 : beam_x_reg;
        eff_by    = restart_reg ? '0 : beam_y_reg;
        eff_halt  = restart_reg ? 1'b0 : halt_reg;
    end

    // Vector operand decode for long and short vectors. The flipped screen
    // negates both components.
    always_comb begin
        op      = first_reg[WORD_W-1:WORD_W-OP_W];
        is_long = (op <= OP_LONG_LAST);
        if (is_long) begin
            mag_y     = first_reg[MAG_W-1:0];
            neg_y     = first_reg[10] ^ screen_flip_reg;
            mag_x     = second_reg[MAG_W-1:0];
            neg_x     = second_reg[10] ^ screen_flip_reg;
            temp_base = op;
            vec_z     = second_reg[WORD_W-1:WORD_W-Z_W];
        end else begin
            mag_y     = {first_reg[9:8], 8'b0};
            neg_y     = first_reg[10] ^ screen_flip_reg;
            mag_x     = {first_reg[1:0], 8'b0};
            neg_x     = first_reg[2] ^ screen_flip_reg;
            temp_base = TEMP_W'(2) + {2'b00, first_reg[3], first_reg[11]};
            vec_z     = first_reg[7:4];
        end
        vec_temp = temp_base + eff_scale;
    end

    vgis_delta #(
        .FRAC_BITS (FRAC_BITS)
    ) u_delta_x (
        .mag   (mag_x),
        .neg   (neg_x),
        .temp  (vec_temp),
        .delta (dx)
    );

    vgis_delta #(
        .FRAC_BITS (FRAC_BITS)
    ) u_delta_y (
        .mag   (mag_y),
        .neg   (neg_y),
        .temp  (vec_temp),
        .delta (dy)
    );

    // Instruction execution and the next architectural state.
    always_comb begin
        pc_seq      = eff_pc + PC_STEP;
        jump_target = PC_RESET + WORD_W'({first_reg[12:0], 1'b0});
        sp_dec      = eff_sp - SP_W'(1);

        // Position: the y axis is always mirrored about the center, and the
        // flipped screen mirrors both axes once more.
        pos_x = {{(POS_W-12){second_reg[11]}}, second_reg[11:0]};
        pos_y = {{(POS_W-12){first_reg[11]}}, first_reg[11:0]};
        if (screen_flip_reg) begin
            pos_x = POS_W'(POS_CENTER) - pos_x;
        end else begin
            pos_y = POS_W'(POS_CENTER) - pos_y;
        end

        nx = eff_bx + dx;
        ny = eff_by - dy;

        pc_next     = eff_pc;
        sp_next     = eff_sp;
        scale_next  = eff_scale;
        beam_x_next = eff_bx;
        beam_y_next = eff_by;
        halt_next   = eff_halt;
        push_en     = 1'b0;
        vec         = 1'b0;
        draw        = 1'b0;
        serr        = 1'b0;

        if (!eff_halt) begin
            pc_next = pc_seq;
            if (is_long) begin
                pc_next = pc_seq + PC_STEP;
                vec     = 1'b1;
            end else begin
                unique case (op)
                    OP_SHORT: begin
                        vec = 1'b1;
                    end
                    OP_POS: begin
                        pc_next     = pc_seq + PC_STEP;
                        scale_next  = second_reg[WORD_W-1:WORD_W-TEMP_W];
                        beam_x_next = {{(BEAM_W-POS_W){pos_x[POS_W-1]}}, pos_x} << FRAC_BITS;
                        beam_y_next = {{(BEAM_W-POS_W){pos_y[POS_W-1]}}, pos_y} << FRAC_BITS;
                    end
                    OP_HALT: begin
                        halt_next = 1'b1;
                    end
                    OP_CALL: begin
                        if (eff_sp < SP_W'(STACK_DEPTH)) begin
                            push_en = 1'b1;
                            sp_next = eff_sp + SP_W'(1);
                            pc_next = jump_target;
                        end else begin
                            serr = 1'b1;
                        end
                    end
                    OP_RET: begin
                        if (eff_sp != '0) begin
                            sp_next = sp_dec;
                            pc_next = stack_reg[sp_dec[IDX_W-1:0]];
                        end else begin
                            serr = 1'b1;
                        end
                    end
                    OP_JUMP: begin
                        pc_next = jump_target;
                    end
                    default: begin
                    end
                endcase
            end

            if (vec) begin
                beam_x_next = nx;
                beam_y_next = ny;
                draw = (vec_z > Z_W'(Z_DRAW_MIN)) && ((dx != '0) || (dy != '0));
            end
        end

        // Display mapping keeps only the bits that survive the 19-bit wrap.
        disp_x0 = eff_bx[DISP_SHIFT+DISP_W-1:DISP_SHIFT] - DISP_W'(DISP_OFFSET);
        disp_y0 = DISP_W'(DISP_OFFSET) - eff_by[DISP_SHIFT+DISP_W-1:DISP_SHIFT];
        disp_x1 = nx[DISP_SHIFT+DISP_W-1:DISP_SHIFT] - DISP_W'(DISP_OFFSET);
        disp_y1 = DISP_W'(DISP_OFFSET) - ny[DISP_SHIFT+DISP_W-1:DISP_SHIFT];
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_flip_reg <= 1'b0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pc_reg          <= PC_RESET;
            sp_reg          <= '0;
            scale_reg       <= '0;
            beam_x_reg      <= '0;
            beam_y_reg      <= '0;
            halt_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                screen_flip_reg <= cfg_wr_data;
            end
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (exec) begin
                in_valid_reg <= 1'b0;
            end
            if (adv_out) begin
                out_valid_reg <= in_valid_reg;
            end
            if (exec) begin
                pc_reg     <= pc_next;
                sp_reg     <= sp_next;
                scale_reg  <= scale_next;
                beam_x_reg <= beam_x_next;
                beam_y_reg <= beam_y_next;
                halt_reg   <= halt_next;
            end
        end
    end

    // Payload registers and the return stack carry no reset.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            first_reg   <= s_first_word;
            second_reg  <= s_second_word;
            restart_reg <= s_restart;
        end
        if (exec && push_en) begin
            stack_reg[eff_sp[IDX_W-1:0]] <= pc_seq;
        end
        if (exec) begin
            next_address_reg <= pc_next;
            draw_valid_reg   <= draw;
            line_x0_reg      <= draw ? disp_x0 : '0;
            line_y0_reg      <= draw ? disp_y0 : '0;
            line_x1_reg      <= draw ? disp_x1 : '0;
            line_y1_reg      <= draw ? disp_y1 : '0;
            intensity_reg    <= draw ? {vec_z, 3'b000} : '0;
            time_units_reg   <= vec ? vec_temp : '0;
            halted_reg       <= halt_next;
            stack_error_reg  <= serr;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_next_address = next_address_reg;
    assign m_draw_valid   = draw_valid_reg;
    assign m_line_x0      = line_x0_reg;
    assign m_line_y0      = line_y0_reg;
    assign m_line_x1      = line_x1_reg;
    assign m_line_y1      = line_y1_reg;
    assign m_intensity    = intensity_reg;
    assign m_time_units   = time_units_reg;
    assign m_halted       = halted_reg;
    assign m_stack_error  = stack_error_reg;

    // The stack pointer never runs past the stack depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // A halted result never draws and never reports vector time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_halted) |-> (!m_draw_valid && (m_time_units == '0)))
        else $error("halted result carries a vector");

    // A refused call or return without restart neither draws nor moves the beam.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && serr && !restart_reg)
            |=> ($stable(beam_x_reg) && $stable(beam_y_reg) && !draw_valid_reg))
        else $error("stack error changed the beam");

    // While halted, an instruction without restart leaves the address alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && halt_reg && !restart_reg) |=> $stable(pc_reg))
        else $error("halted step moved the program address");

    // A result only appears after an item has left the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without an executed instruction");

endmodule

FILE: rtl/vgis_delta.sv
// Scaled beam delta of one vector component.
module vgis_delta
    import vgis_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic [MAG_W-1:0]  mag,
    input  logic              neg,
    input  logic [TEMP_W-1:0] temp,
    output logic [BEAM_W-1:0] delta
);

    logic signed [VEC_W-1:0] comp;
    logic [BEAM_W-1:0]       scaled;
    logic [TEMP_W-1:0]       amt;

    always_comb begin
        comp   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        scaled = {{(BEAM_W-VEC_W){comp[VEC_W-1]}}, comp} << FRAC_BITS;
        // Scale values above the pivot turn the right shift into a left shift.
        if (temp <= TEMP_W'(SHIFT_PIVOT)) begin
            amt   = TEMP_W'(SHIFT_PIVOT) - temp;
            delta = $unsigned($signed(scaled) >>> amt);
        end else begin
            amt   = temp - TEMP_W'(SHIFT_PIVOT);
            delta = scaled << amt;
        end
    end

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the vector generator instruction step.
`timescale 1ns / 1ps

module tb;
    import vgis_pkg::*;

    // The DUT is built with its default sizes; the predictor mirrors them.
    localparam int FRAC_BITS      = FRAC_BITS_DEF;
    localparam int STACK_DEPTH    = STACK_DEPTH_DEF;
    localparam int SP_IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 110;

    // One result transfer, in the order of the m_ ports.
    typedef struct packed {
        logic [WORD_W-1:0] next_address;
        logic              draw_valid;
        logic [DISP_W-1:0] line_x0;
        logic [DISP_W-1:0] line_y0;
        logic [DISP_W-1:0] line_x1;
        logic [DISP_W-1:0] line_y1;
        logic [INT_W-1:0]  intensity;
        logic [TEMP_W-1:0] time_units;
        logic              halted;
        logic              stack_error;
    } step_result_t;

    // Every input is known from time zero; reset is held low at the start.
    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic              cfg_wr_data   = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [WORD_W-1:0] s_first_word  = '0;
    logic [WORD_W-1:0] s_second_word = '0;
    logic              s_restart     = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [WORD_W-1:0] m_next_address;
    logic              m_draw_valid;
    logic signed [DISP_W-1:0] m_line_x0;
    logic signed [DISP_W-1:0] m_line_y0;
    logic signed [DISP_W-1:0] m_line_x1;
    logic signed [DISP_W-1:0] m_line_y1;
    logic [INT_W-1:0]  m_intensity;
    logic [TEMP_W-1:0] m_time_units;
    logic              m_halted;
    logic              m_stack_error;

    vector_generator_instruction_step u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_first_word  (s_first_word),
        .s_second_word (s_second_word),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_address(m_next_address),
        .m_draw_valid  (m_draw_valid),
        .m_line_x0     (m_line_x0),
        .m_line_y0     (m_line_y0),
        .m_line_x1     (m_line_x1),
        .m_line_y1     (m_line_y1),
        .m_intensity   (m_intensity),
        .m_time_units  (m_time_units),
        .m_halted      (m_halted),
        .m_stack_error (m_stack_error)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Percentages of cycles in which the sender holds back and the sink stalls.
    int send_idle_pct  = 0;
    int sink_stall_pct = 0;

    // Results predicted for accepted instructions, oldest first.
    step_result_t pending_results[$];

    int mismatch_count = 0;
    int instr_count    = 0;
    int restart_count  = 0;
    int result_count   = 0;
    int lines_drawn    = 0;
    int stack_refusals = 0;
    int halted_steps   = 0;
    int idle_cycles    = 0;

    // Architectural state as the predictor sees it. It advances once per
    // accepted instruction, in acceptance order.
    logic [WORD_W-1:0] gen_pc = PC_RESET;
    logic [WORD_W-1:0] gen_stack [STACK_DEPTH];
    int                gen_sp = 0;
    logic [TEMP_W-1:0] gen_scale = '0;
    logic [BEAM_W-1:0] gen_beam_x = '0;
    logic [BEAM_W-1:0] gen_beam_y = '0;
    logic              gen_halt = 1'b0;
    logic              gen_flip = 1'b0;

    // Beam movement for one vector component. The magnitude is placed at the
    // fixed-point position and then shifted right by (9 - scale), or left
    // when the scale is past the pivot; everything wraps at 32 bits.
    function automatic logic [BEAM_W-1:0] scaled_delta(input int comp,
                                                      input logic [TEMP_W-1:0] shift);
        logic [BEAM_W-1:0] raw;
        raw = comp << FRAC_BITS;
        if (int'(shift) <= SHIFT_PIVOT)
            return $signed(raw) >>> (SHIFT_PIVOT - int'(shift));
        return raw << (int'(shift) - SHIFT_PIVOT);
    endfunction

    // Beam to display units; y is mirrored around the display offset.
    function automatic logic [DISP_W-1:0] display_x(input logic [BEAM_W-1:0] b);
        return DISP_W'(($signed(b) >>> DISP_SHIFT) - DISP_OFFSET);
    endfunction

    function automatic logic [DISP_W-1:0] display_y(input logic [BEAM_W-1:0] b);
        return DISP_W'(DISP_OFFSET - ($signed(b) >>> DISP_SHIFT));
    endfunction

    // Executes one instruction on the predictor state and returns the
    // result that the block must produce for it.
    function automatic step_result_t execute_instruction(input logic [WORD_W-1:0] w1,
                                                         input logic [WORD_W-1:0] w2,
                                                         input logic rst);
        step_result_t      r;
        logic [OP_W-1:0]   op;
        logic [TEMP_W-1:0] mag_shift;
        logic [Z_W-1:0]    z;
        logic [WORD_W-1:0] pc;
        logic [BEAM_W-1:0] dx, dy, nx, ny;
        logic              is_vec, refused;
        int                vx, vy;
        r = '0;
        op = w1[15:12];
        mag_shift = '0;
        z = '0;
        vx = 0;
        vy = 0;
        is_vec = 1'b0;
        refused = 1'b0;

        if (rst) begin
            gen_pc = PC_RESET;
            gen_sp = 0;
            gen_scale = '0;
            gen_beam_x = '0;
            gen_beam_y = '0;
            gen_halt = 1'b0;
        end

        // A halted generator ignores its words until the next restart.
        if (gen_halt) begin
            r.next_address = gen_pc;
            r.halted = 1'b1;
            return r;
        end

        pc = gen_pc + PC_STEP;
        if (op <= OP_LONG_LAST) begin
            // Long vector: both words, opcode adds to the global scale.
            pc = pc + PC_STEP;
            vy = int'(w1[9:0]);
            vx = int'(w2[9:0]);
            z = w2[15:12];
            if (w1[10]) vy = -vy;
            if (w2[10]) vx = -vx;
            mag_shift = gen_scale + op;
            is_vec = 1'b1;
        end else begin
            case (op)
                OP_SHORT: begin
                    vy = int'({w1[9:8], 8'h00});
                    vx = int'({w1[1:0], 8'h00});
                    z = w1[7:4];
                    if (w1[10]) vy = -vy;
                    if (w1[2]) vx = -vx;
                    mag_shift = gen_scale + 4'd2 + {2'b00, w1[3], 1'b0} + {3'b000, w1[11]};
                    is_vec = 1'b1;
                end
                OP_POS: begin
                    vx = int'($signed(w2[11:0]));
                    vy = int'($signed(w1[11:0]));
                    pc = pc + PC_STEP;
                    if (gen_flip) begin
                        vx = POS_CENTER - vx;
                        vy = POS_CENTER - vy;
                    end
                    gen_scale = w2[15:12];
                    vy = POS_CENTER - vy;
                    gen_beam_y = vy << FRAC_BITS;
                    gen_beam_x = vx << FRAC_BITS;
                end
                OP_HALT: gen_halt = 1'b1;
                OP_CALL: begin
                    if (gen_sp < STACK_DEPTH) begin
                        gen_stack[gen_sp[SP_IDX_W-1:0]] = pc;
                        gen_sp++;
                        pc = PC_RESET + {2'b00, w1[12:0], 1'b0};
                    end else begin
                        refused = 1'b1;
                    end
                end
                OP_RET: begin
                    if (gen_sp > 0) begin
                        gen_sp--;
                        pc = gen_stack[gen_sp[SP_IDX_W-1:0]];
                    end else begin
                        refused = 1'b1;
                    end
                end
                OP_JUMP: pc = PC_RESET + {2'b00, w1[12:0], 1'b0};
                default: ;
            endcase
        end

        if (is_vec) begin
            // A flipped screen mirrors the vector itself, not only its start.
            if (gen_flip) begin
                vx = -vx;
                vy = -vy;
            end
            dx = scaled_delta(vx, mag_shift);
            dy = scaled_delta(vy, mag_shift);
            nx = gen_beam_x + dx;
            ny = gen_beam_y - dy;
            if (z > Z_DRAW_MIN && (dx != '0 || dy != '0)) begin
                r.draw_valid = 1'b1;
                r.line_x0 = display_x(gen_beam_x);
                r.line_y0 = display_y(gen_beam_y);
                r.line_x1 = display_x(nx);
                r.line_y1 = display_y(ny);
                r.intensity = {z, 3'b000};
            end
            gen_beam_x = nx;
            gen_beam_y = ny;
            r.time_units = mag_shift;
        end

        gen_pc = pc;
        r.next_address = pc;
        r.halted = gen_halt;
        r.stack_error = refused;
        return r;
    endfunction

    function automatic string result_text(input step_result_t r);
        return $sformatf("addr=%h draw=%b line=(%0d,%0d)-(%0d,%0d) int=%0d t=%0d halt=%b serr=%b",
                         r.next_address, r.draw_valid, $signed(r.line_x0), $signed(r.line_y0),
                         $signed(r.line_x1), $signed(r.line_y1), r.intensity, r.time_units,
                         r.halted, r.stack_error);
    endfunction

    // Offers one instruction, after a random number of idle cycles, and
    // holds it until the transfer. The expected result is queued at the
    // accepting edge; the DUT answers only after the item has passed its input register into its result register.
    task automatic send_instr(input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                              input logic rst);
        step_result_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_first_word  <= w1;
        s_second_word <= w2;
        s_restart     <= rst;
        do @(posedge aclk); while (!s_ready);
        want = execute_instruction(w1, w2, rst);
        pending_results.push_back(want);
        instr_count++;
        if (rst) restart_count++;
        if (want.draw_valid) lines_drawn++;
        if (want.stack_error) stack_refusals++;
        if (want.halted) halted_steps++;
    endtask

    // Picks a plausible next instruction for a vector program: mostly vectors
    // and positioning with some control flow, halts kept rare, and a few
    // words that are pure noise. A halted generator is usually restarted.
    task automatic send_random_instr();
        logic [31:0]       rnd;
        logic [WORD_W-1:0] w1, w2;
        logic [OP_W-1:0]   op;
        logic [TEMP_W-1:0] scale;
        logic              rst;
        int                pick;
        rnd  = $urandom;
        w2   = WORD_W'($urandom);
        pick = $urandom_range(99);
        rst  = ($urandom_range(99) < 3) || (gen_halt && $urandom_range(99) < 70);
        if (pick < 30) begin
            op = OP_W'($urandom_range(OP_LONG_LAST));
            w1 = {op, rnd[11:0]};
        end else if (pick < 48) begin
            w1 = {OP_SHORT, rnd[11:0]};
        end else if (pick < 60) begin
            // Small scales keep most vectors on screen; large ones still occur.
            scale = ($urandom_range(3) == 0) ? TEMP_W'($urandom_range(15))
                                             : TEMP_W'($urandom_range(2));
            w1 = {OP_POS, rnd[11:0]};
            w2 = {scale, w2[11:0]};
        end else if (pick < 74) begin
            w1 = {OP_CALL, rnd[11:0]};
        end else if (pick < 84) begin
            w1 = {OP_RET, rnd[11:0]};
        end else if (pick < 92) begin
            w1 = {OP_JUMP, rnd[11:0]};
        end else if (pick < 94) begin
            w1 = {OP_HALT, rnd[11:0]};
        end else begin
            w1 = rnd[31:16];
            rst = rnd[0];
        end
        send_instr(w1, w2, rst);
    endtask

    // The register may only change with nothing in flight: wait for the last
    // result, let the input and result registers settle, then write.
    task automatic set_screen_flip(input logic value);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gen_flip = value;
    endtask

    // Positioning and both vector forms, at the extremes of magnitude, scale,
    // sign and brightness, including vectors that draw nothing.
    task automatic test_vectors_and_positions();
        send_instr(16'hA800, 16'hF7FF, 1'b1);  // restart, extreme corner, scale 15
        send_instr(16'h07FF, 16'hFFFF, 1'b0);  // longest negative vector, left shift
        send_instr(16'h03FF, 16'h03FF, 1'b0);  // longest positive vector, z = 0
        send_instr(16'hA000, 16'h1000, 1'b0);  // scale 1
        send_instr(16'h93FF, 16'h23FF, 1'b0);  // scale past the pivot, dimmest visible z
        send_instr(16'h0100, 16'h1100, 1'b0);  // too dim to draw
        send_instr(16'h5000, 16'h8000, 1'b0);  // zero length draws nothing
        send_instr(16'hA000, 16'h0000, 1'b0);  // scale 0
        send_instr(16'hFFFF, 16'h0000, 1'b0);  // short vector, every bit set
        send_instr(16'hF000, 16'hFFFF, 1'b0);  // short zero length; second word unused
    endtask

    // Jumps, the return stack at both limits, and halt with its restart.
    task automatic test_control_flow();
        send_instr({OP_RET, 12'h000}, 16'hFFFF, 1'b1);  // return on an empty stack
        send_instr({OP_JUMP, 12'hFFF}, 16'h0000, 1'b0);
        send_instr({OP_CALL, 12'h000}, 16'h0000, 1'b0);
        send_instr({OP_CALL, 12'hFFF}, 16'h0000, 1'b0);
        send_instr({OP_CALL, 12'h555}, 16'h0000, 1'b0);
        send_instr({OP_CALL, 12'hAAA}, 16'h0000, 1'b0);
        send_instr({OP_CALL, 12'h001}, 16'h0000, 1'b0);  // stack full: refused
        repeat (5) send_instr({OP_RET, 12'h000}, 16'h0000, 1'b0);  // last one underflows
        send_instr({OP_HALT, 12'h000}, 16'h0000, 1'b0);
        send_instr(16'h0123, 16'hFFFF, 1'b0);  // ignored while halted
        send_instr(16'h4ABC, 16'hF3FF, 1'b1);  // restart out of the halt with a vector
    endtask

    // Mirrored screen: positions and vectors flip, then a random stretch.
    task automatic test_flipped_screen();
        set_screen_flip(1'b1);
        send_instr(16'hA800, 16'h27FF, 1'b1);
        send_instr(16'h07FF, 16'hFFFF, 1'b0);
        send_instr(16'hFFFF, 16'h0000, 1'b0);
        repeat (50) send_random_instr();
    endtask

    // Random programs under each flow-control pattern, alternating the flip.
    task automatic test_random_programs();
        int send_pcts[4] = '{0, 82, 0, 38};
        int sink_pcts[4] = '{0, 0, 82, 38};
        for (int phase = 0; phase < 4; phase++) begin
            set_screen_flip(phase[0]);
            send_idle_pct  = send_pcts[phase];
            sink_stall_pct = sink_pcts[phase];
            repeat (PHASE_ITEMS) send_random_instr();
        end
    endtask

    // Drains the pipeline, watches a few more cycles for stray results and
    // prints the verdict.
    task automatic finish_run();
        s_valid <= 1'b0;
        sink_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        $display("Ran %0d instructions (%0d with restart) and checked %0d results.",
                 instr_count, restart_count, result_count);
        $display("Seen: %0d lines drawn, %0d stack refusals, %0d halted steps, %0d mismatches.",
                 lines_drawn, stack_refusals, halted_steps, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        set_screen_flip(1'b0);
        send_idle_pct  = 38;
        sink_stall_pct = 38;
        test_vectors_and_positions();
        test_control_flow();
        test_flipped_screen();
        test_random_programs();
        finish_run();
    end

    // The sink's ready is redrawn every cycle from the current stall rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Every result transfer is compared against the oldest prediction. The
    // values read here are those present at the edge, since the DUT and the
    // drivers only update through nonblocking assignments.
    always @(posedge aclk) begin
        step_result_t seen;
        step_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_next_address, m_draw_valid, m_line_x0, m_line_y0, m_line_x1,
                    m_line_y1, m_intensity, m_time_units, m_halted, m_stack_error};
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result transfer: %s", result_text(seen));
            end else begin
                want = pending_results.pop_front();
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("ERROR: result %0d mismatch", result_count);
                        $display("  expected %s", result_text(want));
                        $display("  actual   %s", result_text(seen));
                    end
                end
            end
        end
    end

    // Ends a hung run: too many cycles in a row without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
                     WATCHDOG_LIMIT, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
